FILE: rtl/urd_pkg.sv
// Shared types and constants for the serial response deframer.
// Used by urd_parser, urd_out_buf and the top level; no dependencies.
package urd_pkg;

  // Frame header codes
  localparam logic [7:0] HDR_ACK = 8'hEE;
  localparam logic [7:0] HDR_RSP = 8'hBB;

  // Payload bytes kept per read response; later bytes are dropped
  localparam int unsigned PAYLOAD_BYTES = 24;
  localparam int unsigned PIDX_W        = $clog2(PAYLOAD_BYTES);

  // Decoded words: accel xyz, rate xyz, heading, bank, tilt
  localparam int unsigned NUM_WORDS = 9;
  localparam int unsigned WORD_OFFS [NUM_WORDS] = '{0, 2, 4, 12, 14, 16, 18, 20, 22};

  typedef enum logic [1:0] {
    KIND_ACK      = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_IDLE_RSP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic [7:0]                    ack_status;
    logic [7:0]                    payload_length;
    logic [NUM_WORDS-1:0][15:0]    words;
  } res_t;

endpackage

FILE: rtl/urd_parser.sv
// Frame parser: header/length tracking, payload store and word unpacking.
// Depends on urd_pkg. Result is combinational from the transfer and state.
module urd_parser
  import urd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       func,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output res_t       res
);

  logic [8:0] pos, pos_next;
  logic [7:0] hdr, hdr_next;
  logic [7:0] len, len_next;
  logic       awaiting, awaiting_next;
  logic [7:0] store      [PAYLOAD_BYTES];
  logic [7:0] store_next [PAYLOAD_BYTES];

  logic [8:0]        off;
  logic [8:0]        pos_inc;
  logic              wr_en;
  logic [PIDX_W-1:0] widx;
  logic              finish;
  logic [7:0]        fin_len;

  assign off     = pos - 9'd2;
  assign pos_inc = pos + 9'd1;
  assign widx    = off[PIDX_W-1:0];

  always_comb begin
    pos_next      = pos;
    hdr_next      = hdr;
    len_next      = len;
    awaiting_next = awaiting;
    wr_en         = 1'b0;
    finish        = 1'b0;
    fin_len       = len;
    res_valid     = 1'b0;
    res           = '0;

    if (take) begin
      if (func) begin
        awaiting_next = 1'b1;
      end else if (pos == 9'd0) begin
        if (rx_byte == HDR_ACK || rx_byte == HDR_RSP) begin
          hdr_next = rx_byte;
          pos_next = 9'd1;
        end
      end else if (pos == 9'd1) begin
        len_next = rx_byte;
        if (hdr == HDR_ACK) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ACK;
          res.ack_status = rx_byte;
          awaiting_next  = 1'b0;
          pos_next       = 9'd0;
        end else begin
          pos_next = 9'd2;
          fin_len  = rx_byte;
          finish   = (rx_byte == 8'd0);
        end
      end else if (hdr != HDR_RSP) begin
        // stray position, resync
        pos_next = 9'd0;
      end else begin
        wr_en    = (off < 9'(PAYLOAD_BYTES));
        pos_next = pos_inc;
        finish   = ({1'b0, pos_inc} >= ({2'b00, len} + 10'd2));
      end
    end

    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      store_next[i] = (wr_en && widx == PIDX_W'(i)) ? rx_byte : store[i];
    end

    if (finish) begin
      pos_next           = 9'd0;
      res_valid          = 1'b1;
      res.payload_length = fin_len;
      if (awaiting) begin
        res.kind = KIND_DATA;
        for (int k = 0; k < NUM_WORDS; k++) begin
          res.words[k] = {store_next[PIDX_W'(WORD_OFFS[k] + 1)],
                          store_next[PIDX_W'(WORD_OFFS[k])]};
        end
      end else begin
        res.kind = KIND_IDLE_RSP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      hdr      <= '0;
      len      <= '0;
      awaiting <= 1'b0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        store[i] <= '0;
      end
    end else begin
      pos      <= pos_next;
      hdr      <= hdr_next;
      len      <= len_next;
      awaiting <= awaiting_next;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

endmodule

FILE: rtl/urd_out_buf.sv
// Result register plus one skid entry between parser and output channel.
// Depends on urd_pkg for the result struct.
module urd_out_buf
  import urd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  input  logic out_stall,
  output logic full,
  output logic out_valid,
  output res_t out_res
);

  logic out_vld, out_vld_next;
  logic skid_vld, skid_vld_next;
  res_t out_q, out_q_next;
  res_t skid_q, skid_q_next;
  logic out_free;

  assign out_free = !out_vld || !out_stall;

  always_comb begin
    out_vld_next  = out_vld;
    skid_vld_next = skid_vld;
    out_q_next    = out_q;
    skid_q_next   = skid_q;
    if (out_free) begin
      if (skid_vld) begin
        out_q_next   = skid_q;
        out_vld_next = 1'b1;
        skid_q_next   = push_res;
        skid_vld_next = push;
      end else begin
        out_q_next   = push_res;
        out_vld_next = push;
      end
    end else if (push) begin
      skid_q_next   = push_res;
      skid_vld_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      out_vld  <= out_vld_next;
      skid_vld <= skid_vld_next;
    end
    out_q  <= out_q_next;
    skid_q <= skid_q_next;
  end

  assign full      = skid_vld;
  assign out_valid = out_vld;
  assign out_res   = out_q;

endmodule

FILE: rtl/imu_uart_response_deframer.sv
// Serial response deframer: one byte or request per transfer, 1 per cycle while in_stall is low.
// The result of the closing byte's transfer is registered into the output register or the skid entry.
// Throughput: one input transfer every cycle; in_stall rises only when the
// output register and the skid entry both hold untaken results.
// Reset (rst, synchronous) clears position, header, length, await flag,
// the 24-byte payload store to zero, and empties both output stages.
module imu_uart_response_deframer
  import urd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               func,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         frame_kind,
  output logic [7:0]         ack_status,
  output logic [7:0]         payload_length,
  output logic signed [15:0] accel_x,
  output logic signed [15:0] accel_y,
  output logic signed [15:0] accel_z,
  output logic signed [15:0] rate_x,
  output logic signed [15:0] rate_y,
  output logic signed [15:0] rate_z,
  output logic signed [15:0] heading,
  output logic signed [15:0] bank,
  output logic signed [15:0] tilt
);

  logic take;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic buf_full;

  // Input transfer happens whenever in_valid is high and the skid entry is free
  assign in_stall = buf_full;
  assign take     = in_valid && !buf_full;

  // Parser: all per-byte work is a single combinational pass
  urd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .func      (func),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register with skid, decouples out_stall from in_stall timing
  urd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (res),
    .out_stall (out_stall),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // Unpack result fields; words are little-endian pairs from the payload
  assign frame_kind     = out_res.kind;
  assign ack_status     = out_res.ack_status;
  assign payload_length = out_res.payload_length;
  assign accel_x        = out_res.words[0];
  assign accel_y        = out_res.words[1];
  assign accel_z        = out_res.words[2];
  assign rate_x         = out_res.words[3];
  assign rate_y         = out_res.words[4];
  assign rate_z         = out_res.words[5];
  assign heading        = out_res.words[6];
  assign bank           = out_res.words[7];
  assign tilt           = out_res.words[8];

`ifndef SYNTHESIS
  // Skid entry only fills behind a held output register
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("in_stall without a pending output");

  // Raw counts are zero unless a data response was decoded
  a_words_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_kind != KIND_DATA) |->
      (accel_x == 16'sd0 && accel_y == 16'sd0 && accel_z == 16'sd0 &&
       rate_x == 16'sd0 && rate_y == 16'sd0 && rate_z == 16'sd0 &&
       heading == 16'sd0 && bank == 16'sd0 && tilt == 16'sd0))
    else $error("nonzero words on a non-data result");

  // Acknowledge carries only status; responses carry no status
  a_ack_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((frame_kind == KIND_ACK && payload_length == 8'd0) ||
       (frame_kind != KIND_ACK && ack_status == 8'd0)))
    else $error("acknowledge/response field mix-up");
`endif

endmodule
